FILE: sv/ndt_pkg.sv
// Shared types, constants and helpers for the name-keyed directory table.
// Depends on nothing; ndt_ctrl, the top level and the testbench import it.
package ndt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int NAME_CHARS    = 8;
  localparam int SECTOR_BITS   = 10;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W = 8 * NAME_CHARS;

  localparam int CMD_W       = 2;
  localparam int KEY_IN_W    = 64;
  localparam int SEC_IN_W    = 10;
  localparam int STAT_W      = 2;
  localparam int FOUND_W     = 10;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = ((KEY_IN_W + SEC_IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + FOUND_W + SLOT_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [KEY_W-1:0]       key;
    logic [SECTOR_BITS-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [SECTOR_BITS-1:0] sector;
    logic [IDX_W-1:0]       idx;
  } res_t;

  // Keeps the low name characters up to the first zero byte.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_IN_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic             run;
    k   = '0;
    run = 1'b1;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (raw[8*i +: 8] == 8'd0) run = 1'b0;
      if (run) k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

endpackage

FILE: sv/ndt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: sv/ndt_ctrl.sv
// Scan sequencer of the directory table: valid bits, entry memory, match logic.
// Depends on ndt_pkg and ndt_ram.
module ndt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ndt_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_take,
  output ndt_pkg::res_t res
);
  import ndt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;
  localparam int MEM_W = KEY_W + SECTOR_BITS;

  logic [1:0]               state;
  logic [CNT_W-1:0]         cnt;
  logic                     cmp_v;
  logic [IDX_W-1:0]         cmp_idx;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  req_t                     req_q;
  logic                     hit_q;
  logic [IDX_W-1:0]         hit_idx;
  logic [SECTOR_BITS-1:0]   hit_sec;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx;
  res_t                     res_q;
  res_t                     res_next;

  logic             rd_en;
  logic [MEM_W-1:0] rd_data;
  logic             name_eq;
  logic             do_add;
  logic             do_remove;

  assign rd_en     = (state == S_SCAN) && (cnt != CNT_W'(TABLE_ENTRIES));
  assign name_eq   = (rd_data[MEM_W-1:SECTOR_BITS] == req_q.key);
  assign do_add    = (state == S_FINISH) && (req_q.cmd == CMD_ADD) && !hit_q && free_q;
  assign do_remove = (state == S_FINISH) && (req_q.cmd == CMD_REMOVE) && hit_q;

  ndt_ram #(
    .WIDTH(MEM_W),
    .DEPTH(TABLE_ENTRIES),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (do_add),
    .waddr(free_idx),
    .wdata({req_q.key, req_q.sector}),
    .re   (rd_en),
    .raddr(cnt[IDX_W-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    res_next        = '0;
    res_next.status = STAT_NOT_FOUND;
    unique case (req_q.cmd)
      CMD_FIND: begin
        if (hit_q) begin
          res_next.status = STAT_OK;
          res_next.sector = hit_sec;
          res_next.idx    = hit_idx;
        end
      end
      CMD_ADD: begin
        if (hit_q) begin
          res_next.status = STAT_PRESENT;
        end else if (free_q) begin
          res_next.status = STAT_OK;
          res_next.idx    = free_idx;
        end else begin
          res_next.status = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit_q) begin
          res_next.status = STAT_OK;
          res_next.idx    = hit_idx;
        end
      end
      default: begin
        res_next.status = STAT_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      cmp_v      <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      valid_bits <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q  <= req;
            cnt    <= '0;
            cmp_v  <= 1'b0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            state <= S_FINISH;
          end
          cmp_v   <= rd_en;
          cmp_idx <= cnt[IDX_W-1:0];
          if (cmp_v && valid_bits[cmp_idx] && name_eq && !hit_q) begin
            hit_q   <= 1'b1;
            hit_idx <= cmp_idx;
            hit_sec <= rd_data[SECTOR_BITS-1:0];
          end
          if (cmp_v && !valid_bits[cmp_idx] && !free_q) begin
            free_q   <= 1'b1;
            free_idx <= cmp_idx;
          end
        end
        S_FINISH: begin
          res_q <= res_next;
          if (do_add) valid_bits[free_idx] <= 1'b1;
          if (do_remove) valid_bits[hit_idx] <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    do_add |=> valid_bits[free_idx])
    else $error("add did not mark its slot valid");

  a_remove_clears_valid: assert property (@(posedge clk) disable iff (rst)
    do_remove |=> !valid_bits[hit_idx])
    else $error("remove did not clear the matched slot");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && hit_q) |-> valid_bits[hit_idx])
    else $error("match recorded on an entry that is not valid");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !rd_en) |-> (cnt == CNT_W'(TABLE_ENTRIES)))
    else $error("scan ended before every entry was read");

endmodule

FILE: sv/name_keyed_directory_table.sv
// Top level of the name-keyed directory table: stream ports, key cleanup, output register.
// Depends on ndt_pkg and ndt_ctrl.
//
// Each request is a find, an add or a remove against a table of TABLE_ENTRIES entries; any
// other command returns not found. A request reads every entry of the table memory once,
// one per cycle, then writes back, and a new request can be accepted only once the previous
// result has moved into the output register. Name keys are compared up to the first zero
// byte. The table is empty after reset and needs no clearing pass.
module name_keyed_directory_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: name_key [63:0], new_sector [73:64], zero [79:74]
  input  logic [ndt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [ndt_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: status [1:0], found_sector [11:2], slot [15:12]
  output logic [ndt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ndt_pkg::*;

  req_t                   req;
  res_t                   res;
  logic                   res_valid;
  logic                   res_take;
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  assign req.cmd    = s_axis_tuser;
  assign req.key    = norm_key(s_axis_tdata[KEY_IN_W-1:0]);
  assign req.sector = SECTOR_BITS'(s_axis_tdata[KEY_IN_W +: SEC_IN_W]);

  ndt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_axis_tvalid),
    .req_ready(s_axis_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  assign res_take = res_valid && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= OUT_TDATA_W'({SLOT_W'(res.idx), FOUND_W'(res.sector), res.status});
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for name_keyed_directory_table: directed and random requests
// against a behavioral copy of the directory. Depends on ndt_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import ndt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found;
    logic [3:0] slot;
  } dir_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = CMD_FIND;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic                   calm = 1'b0;
  int                     fail_count = 0;
  dir_result_t            pending_results[$];
  dir_result_t            oldest;
  dir_result_t            observed;

  logic                   dir_valid [TABLE_ENTRIES];
  logic [63:0]            dir_name [TABLE_ENTRIES];
  logic [9:0]             dir_sector [TABLE_ENTRIES];
  logic [63:0]            name_pool [32];

  name_keyed_directory_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Only characters before the first zero byte are part of the name.
  function automatic logic [63:0] clean_name(input logic [63:0] raw);
    logic [63:0] name;
    bit          ended;
    name  = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_CHARS; b++) begin
      ended = ended || (raw[8*b +: 8] == 8'd0);
      if (!ended) name[8*b +: 8] = raw[8*b +: 8];
    end
    return name;
  endfunction

  function automatic dir_result_t predict_directory(input logic [1:0] op,
                                                    input logic [63:0] raw_key,
                                                    input logic [9:0] sector);
    dir_result_t r;
    logic [63:0] name;
    int          hit;
    int          free;
    name = clean_name(raw_key);
    r    = '{STAT_NOT_FOUND, 10'd0, 4'd0};
    hit  = -1;
    free = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (dir_valid[i] && dir_name[i] == name) hit = i;
      if (!dir_valid[i]) free = i;
    end
    case (op)
      CMD_FIND: begin
        if (hit >= 0) r = '{STAT_OK, dir_sector[hit], 4'(hit)};
      end
      CMD_ADD: begin
        if (hit >= 0) begin
          r.status = STAT_PRESENT;
        end else if (free < 0) begin
          r.status = STAT_FULL;
        end else begin
          dir_valid[free]  = 1'b1;
          dir_name[free]   = name;
          dir_sector[free] = sector;
          r = '{STAT_OK, 10'd0, 4'(free)};
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          dir_valid[hit] = 1'b0;
          r = '{STAT_OK, 10'd0, 4'(hit)};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] fresh_name();
    logic [63:0] name;
    int          len;
    name = '0;
    len  = $urandom_range(0, 8);
    for (int b = 0; b < len; b++) name[8*b +: 8] = 8'($urandom_range(1, 255));
    return name;
  endfunction

  // Mostly names already in the table or in a small shared pool, so that requests
  // hit, collide and miss; bytes past the end of a short name are often filled with junk.
  function automatic logic [63:0] random_key(input int reuse_pct);
    logic [63:0] key;
    int          pick;
    int          start;
    int          len;
    pick = $urandom_range(99);
    key  = fresh_name();
    if (pick < reuse_pct) begin
      start = $urandom_range(TABLE_ENTRIES - 1);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (dir_valid[(start + i) % TABLE_ENTRIES]) key = dir_name[(start + i) % TABLE_ENTRIES];
      end
    end else if (pick < reuse_pct + 25) begin
      key = name_pool[$urandom_range(31)];
    end else if (pick < reuse_pct + 35) begin
      return {$urandom, $urandom};
    end
    len = 0;
    while (len < 8 && key[8*len +: 8] != 8'd0) len++;
    if ($urandom_range(1) == 1) begin
      for (int b = len + 1; b < 8; b++) key[8*b +: 8] = 8'($urandom_range(255));
    end
    return key;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [63:0] raw_key,
                              input logic [9:0] sector);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, sector, raw_key};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_directory(op, raw_key, sector));
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int count, input int add_pct, input int remove_pct);
    int          pick;
    logic [1:0]  op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < add_pct) op = CMD_ADD;
      else if (pick < add_pct + remove_pct) op = CMD_REMOVE;
      else if (pick < 96) op = CMD_FIND;
      else op = CMD_UNUSED;
      send_request(op, random_key(55), 10'($urandom_range(1023)));
    end
  endtask

  task automatic test_directed();
    send_request(CMD_FIND, 64'h0000_0000_0000_4241, 10'd1);
    send_request(CMD_REMOVE, 64'h0000_0000_0000_4241, 10'd2);
    send_request(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
    send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
    send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FF00, 10'd0);
    send_request(CMD_ADD, 64'hA5C3_0000_5A00_0041, 10'd5);
    send_request(CMD_FIND, 64'h1234_5678_9A00_0041, 10'd0);
    send_request(CMD_ADD, 64'h0000_0000_0000_0041, 10'd7);
    send_request(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send_request(CMD_REMOVE, 64'h0000_0000_0000_0000, 10'd0);
    send_request(CMD_FIND, 64'h0000_0000_0000_0000, 10'd0);
    for (int i = 0; i < 15; i++) begin
      send_request(CMD_ADD, {48'd0, 8'(8'h30 + i), 8'h46}, 10'(1008 + i));
    end
  endtask

  task automatic test_fill_heavy();
    run_random_phase(350, 55, 15);
  endtask

  task automatic test_back_to_back();
    calm <= 1'b1;
    run_random_phase(350, 35, 35);
    calm <= 1'b0;
  endtask

  task automatic test_drain_heavy();
    run_random_phase(350, 15, 45);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed.status = m_axis_tdata[1:0];
      observed.found  = m_axis_tdata[11:2];
      observed.slot   = m_axis_tdata[15:12];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, status", observed.status, -1);
      end else begin
        oldest = pending_results.pop_front();
        if (observed.status != oldest.status)
          report_mismatch("status", observed.status, oldest.status);
        if (observed.found != oldest.found)
          report_mismatch("found_sector", observed.found, oldest.found);
        if (observed.slot != oldest.slot)
          report_mismatch("slot", observed.slot, oldest.slot);
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      dir_valid[i]  = 1'b0;
      dir_name[i]   = '0;
      dir_sector[i] = '0;
    end
    for (int i = 0; i < 32; i++) name_pool[i] = fresh_name();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_heavy();
    test_back_to_back();
    test_drain_heavy();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
